### design/otq_pkg.sv
// Shared types, widths and codes for the one-shot timer queue.
`default_nettype none
package otq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int TICK_W        = 16;
   localparam int ID_W          = 8;
   localparam int PEND_W        = 5;
   localparam int KIND_W        = 2;

   // request selector carried on req_tuser
   localparam logic FUNC_TICK     = 1'b0;
   localparam logic FUNC_SCHEDULE = 1'b1;

   // result kind carried on rsp_tuser
   localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FULL     = 2'd2;

   // per-cycle command broadcast to every cell
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DECR,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      logic              valid;
      logic [TICK_W-1:0] ticks;
      logic [ID_W-1:0]   id;
   } slot_type;

   typedef struct packed {
      cell_op_type       op;
      logic [TICK_W-1:0] new_ticks;
      logic [ID_W-1:0]   new_id;
   } cell_ctrl_type;

endpackage
`default_nettype wire

### design/otq_cell.sv
// One slot of the sorted timer chain.
`default_nettype none
module otq_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  otq_pkg::cell_ctrl_type ctrl,
   input  otq_pkg::slot_type      left_slot,   // neighbor closer to the head
   input  wire                    left_ins,
   input  otq_pkg::slot_type      right_slot,  // neighbor closer to the tail
   output otq_pkg::slot_type      slot,
   output logic                   ins
);

   otq_pkg::slot_type slot_ff;
   otq_pkg::slot_type slot_in;

   // new entry belongs at or before this slot
   assign ins  = !slot_ff.valid || (slot_ff.ticks > ctrl.new_ticks);
   assign slot = slot_ff;

   always_comb begin
      slot_in = slot_ff;
      unique case (ctrl.op)
         otq_pkg::CELL_HOLD: begin
            slot_in = slot_ff;
         end
         otq_pkg::CELL_INSERT: begin
            if (ins && !left_ins) begin
               slot_in.valid = 1'b1;
               slot_in.ticks = ctrl.new_ticks;
               slot_in.id    = ctrl.new_id;
            end else if (ins) begin
               slot_in = left_slot;
            end
         end
         otq_pkg::CELL_DECR: begin
            if (slot_ff.valid) begin
               slot_in.ticks = slot_ff.ticks - otq_pkg::TICK_W'(1);
            end
         end
         otq_pkg::CELL_SHIFT: begin
            slot_in = right_slot;
         end
         default: begin
            slot_in = slot_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in.valid;
      end
      slot_ff.ticks <= slot_in.ticks;
      slot_ff.id    <= slot_in.id;
   end

endmodule
`default_nettype wire

### design/otq_chain.sv
// Row of timer cells, head at index 0, kept sorted by remaining ticks.
`default_nettype none
module otq_chain #(
   parameter int DEPTH = otq_pkg::DEPTH_DEFAULT
) (
   input  wire                    clock,
   input  wire                    reset,
   input  otq_pkg::cell_ctrl_type ctrl,
   output otq_pkg::slot_type      head_slot,
   output otq_pkg::slot_type      next_slot,
   output logic [DEPTH-1:0]       valid_vec
);

   localparam otq_pkg::slot_type EMPTY_SLOT = '0;

   otq_pkg::slot_type slots [DEPTH];
   logic              ins   [DEPTH];

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         otq_pkg::slot_type left_s;
         otq_pkg::slot_type right_s;
         logic              left_i;

         if (g == 0) begin : g_head
            assign left_s = EMPTY_SLOT;
            assign left_i = 1'b0;
         end else begin : g_mid
            assign left_s = slots[g-1];
            assign left_i = ins[g-1];
         end

         if (g == DEPTH-1) begin : g_tail
            assign right_s = EMPTY_SLOT;
         end else begin : g_body
            assign right_s = slots[g+1];
         end

         otq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .left_slot  (left_s),
            .left_ins   (left_i),
            .right_slot (right_s),
            .slot       (slots[g]),
            .ins        (ins[g])
         );

         assign valid_vec[g] = slots[g].valid;
      end
   endgenerate

   assign head_slot = slots[0];
   assign next_slot = slots[1];

endmodule
`default_nettype wire

### design/one_shot_timer_queue_core.sv
// Top level of the one-shot timer queue: control, result register and cell chain.
// Schedule: accepted when idle and the result register is free, result transfer offered the cycle after;
// one per cycle while results are taken. Tick: the accepted tick decrements every cell, then one
// result per cycle for each expiring timer while results are taken; with none due it returns to idle.
// One request is worked on at a time; the next one is taken once the last result is queued.
// Synchronous active-high reset empties the queue; slot payloads are not cleared.
`default_nettype none
module one_shot_timer_queue_core #(
   parameter int DEPTH = otq_pkg::DEPTH_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // [7:0] callback_id, [23:8] delay_ticks
   input  wire         req_tuser,   // [0] func
   // result channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] fired_id, [12:8] pending_count, [15:13] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last result of this request
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   // controller states
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_FIRE = 1'b1;

   logic state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [otq_pkg::KIND_W-1:0]      rsp_kind_ff,  rsp_kind_in;
   logic [otq_pkg::ID_W-1:0]        rsp_id_ff,    rsp_id_in;
   logic [otq_pkg::PEND_W-1:0]      rsp_pend_ff,  rsp_pend_in;
   logic                            rsp_last_ff,  rsp_last_in;

   otq_pkg::cell_ctrl_type ctrl;
   otq_pkg::slot_type      head_slot, next_slot;
   logic [DEPTH-1:0]       valid_vec;

   logic [otq_pkg::ID_W-1:0]   req_id;
   logic [otq_pkg::TICK_W-1:0] req_delay, delay_eff;
   logic                       slot_free, accept, is_sched, full;
   logic                       head_due, next_due, fire_go;

   assign req_id    = req_tdata[7:0];
   assign req_delay = req_tdata[23:8];
   // zero delay behaves as one tick
   assign delay_eff = (req_delay == '0) ? otq_pkg::TICK_W'(1) : req_delay;

   // result register can take a new value this cycle
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign is_sched   = (req_tuser == otq_pkg::FUNC_SCHEDULE);
   assign full       = (count_ff == CNT_W'(DEPTH));

   // sorted chain: expiring timers always sit at the head
   assign head_due = head_slot.valid && (head_slot.ticks == '0);
   assign next_due = next_slot.valid && (next_slot.ticks == '0);
   assign fire_go  = (state_ff == ST_FIRE) && head_due && slot_free;

   // broadcast command to the cells
   always_comb begin
      ctrl.new_ticks = delay_eff;
      ctrl.new_id    = req_id;
      priority if (accept && is_sched && !full) begin
         ctrl.op = otq_pkg::CELL_INSERT;
      end else if (accept && !is_sched) begin
         ctrl.op = otq_pkg::CELL_DECR;
      end else if (fire_go) begin
         ctrl.op = otq_pkg::CELL_SHIFT;   // pop head, everything moves up
      end else begin
         ctrl.op = otq_pkg::CELL_HOLD;
      end
   end

   otq_chain #(
      .DEPTH (DEPTH)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .head_slot (head_slot),
      .next_slot (next_slot),
      .valid_vec (valid_vec)
   );

   // controller, count and result register next values
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_pend_in  = rsp_pend_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      priority if (accept && is_sched) begin
         rsp_valid_in = 1'b1;
         rsp_id_in    = req_id;
         rsp_last_in  = 1'b1;
         if (full) begin
            rsp_kind_in = otq_pkg::KIND_FULL;
            rsp_pend_in = otq_pkg::PEND_W'(count_ff);
         end else begin
            count_in    = count_ff + CNT_W'(1);
            rsp_kind_in = otq_pkg::KIND_ACCEPTED;
            rsp_pend_in = otq_pkg::PEND_W'(count_in);
         end
      end else if (accept) begin
         state_in = ST_FIRE;
      end else if (fire_go) begin
         count_in     = count_ff - CNT_W'(1);
         rsp_valid_in = 1'b1;
         rsp_kind_in  = otq_pkg::KIND_FIRED;
         rsp_id_in    = head_slot.id;
         rsp_pend_in  = otq_pkg::PEND_W'(count_in);
         rsp_last_in  = !next_due;
         if (!next_due) begin
            state_in = ST_IDLE;
         end
      end else if ((state_ff == ST_FIRE) && !head_due) begin
         state_in = ST_IDLE;   // tick with nothing due
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_pend_ff <= rsp_pend_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {3'b000, rsp_pend_ff, rsp_id_ff};

   // occupied cells form a prefix whose length is the count
   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(count_ff))
      else $error("cell occupancy disagrees with entry count");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   // a pop always loads a fired result
   a_pop_gives_fired: assert property (@(posedge clock) disable iff (reset)
      fire_go |=> (rsp_valid_ff && (rsp_kind_ff == otq_pkg::KIND_FIRED)))
      else $error("popped timer not presented as fired result");

   // a rejected schedule leaves the queue as it was
   a_full_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (accept && is_sched && full) |=> (count_ff == $past(count_ff)))
      else $error("rejected schedule changed the entry count");

endmodule
`default_nettype wire
